/* hdl/crpm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crpm_pkg
// Shared types, register indexes and the restoring-division step used by the
// color range pixel mask pipeline.
// ----------------------------------------------------------------------------
package crpm_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned OPA_W = 9;
  localparam int unsigned BND_W = 24;
  localparam int unsigned ADDR_W = 3;

  // Two quotient bits per stage, eight quotient bits in total.
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned BITS_PER_STAGE = 2;

  // Register indexes on the configuration port.
  localparam logic [ADDR_W-1:0] REG_FILTER_MODE = 3'd0;
  localparam logic [ADDR_W-1:0] REG_MASK_OPACITY = 3'd1;
  localparam logic [ADDR_W-1:0] REG_RGB_LOWER = 3'd2;
  localparam logic [ADDR_W-1:0] REG_RGB_UPPER = 3'd3;
  localparam logic [ADDR_W-1:0] REG_HSV_LOWER = 3'd4;
  localparam logic [ADDR_W-1:0] REG_HSV_UPPER = 3'd5;

  localparam logic MODE_RGB = 1'b0;
  localparam logic MODE_HSV = 1'b1;

  localparam logic [OPA_W-1:0] RST_MASK_OPACITY = 9'd128;
  localparam logic [BND_W-1:0] RST_RGB_LOWER = 24'h000000;
  localparam logic [BND_W-1:0] RST_RGB_UPPER = 24'hFFFFFF;
  localparam logic [BND_W-1:0] RST_HSV_LOWER = 24'h000000;
  localparam logic [BND_W-1:0] RST_HSV_UPPER = 24'hFFFFB3;

  // Which channel holds the maximum.
  localparam logic [1:0] SEC_RED = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] v;      // maximum channel, divisor for saturation
    logic [PIX_W-1:0] d;      // max - min, divisor for hue
    logic [1:0]       sector;
    logic             neg;    // hue offset goes below the sector base
    logic [PIX_W-1:0] s_rem;
    logic [PIX_W-1:0] s_wrk;  // dividend bits shift out, quotient bits shift in
    logic [PIX_W-1:0] h_rem;
    logic [PIX_W-1:0] h_wrk;
  } pix_t;

  typedef struct packed {
    logic             filter_mode;
    logic [OPA_W-1:0] mask_opacity;
    logic [BND_W-1:0] rgb_lower;
    logic [BND_W-1:0] rgb_upper;
    logic [BND_W-1:0] hsv_lower;
    logic [BND_W-1:0] hsv_upper;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic             hit;
  } cls_t;

  // One restoring step: returns {quotient bit, new remainder}.
  function automatic logic [PIX_W:0] div_step(logic [PIX_W-1:0] rem, logic din,
                                              logic [PIX_W-1:0] den);
    logic [PIX_W:0] t;
    logic [PIX_W:0] diff;
    t = {rem, din};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      return {1'b1, diff[PIX_W-1:0]};
    end else begin
      return {1'b0, t[PIX_W-1:0]};
    end
  endfunction

  // Advances both divisions by one pipeline stage worth of quotient bits.
  function automatic pix_t div_advance(pix_t p);
    pix_t q;
    logic [PIX_W:0] st;
    q = p;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      st = div_step(q.s_rem, q.s_wrk[PIX_W-1], q.v);
      q.s_rem = st[PIX_W-1:0];
      q.s_wrk = {q.s_wrk[PIX_W-2:0], st[PIX_W]};
      st = div_step(q.h_rem, q.h_wrk[PIX_W-1], q.d);
      q.h_rem = st[PIX_W-1:0];
      q.h_wrk = {q.h_wrk[PIX_W-2:0], st[PIX_W]};
    end
    return q;
  endfunction

endpackage
`default_nettype wire

/* hdl/color_range_pixel_mask.sv */
`default_nettype none
// Throughput: one pixel per clock while the output is not stalled.
// The saturation and hue divisions run in a four-stage pipeline at two quotient
// bits per stage, which sets the depth.
// A stall on the output holds every full stage in the same cycle; empty stages still fill.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// color_range_pixel_mask
// Tests each RGB pixel against RGB or HSV ranges and dims non-matching pixels
// by the configured opacity.
// ----------------------------------------------------------------------------
module color_range_pixel_mask (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,    // red_in [7:0], green_in [15:8], blue_in [23:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
  output logic [0:0]       out_tuser,   // in_range [0]
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [23:0] cfg_wr_data
);

  crpm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_mode <= crpm_pkg::MODE_RGB;
      cfg_r.mask_opacity <= crpm_pkg::RST_MASK_OPACITY;
      cfg_r.rgb_lower <= crpm_pkg::RST_RGB_LOWER;
      cfg_r.rgb_upper <= crpm_pkg::RST_RGB_UPPER;
      cfg_r.hsv_lower <= crpm_pkg::RST_HSV_LOWER;
      cfg_r.hsv_upper <= crpm_pkg::RST_HSV_UPPER;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        crpm_pkg::REG_FILTER_MODE:  cfg_r.filter_mode <= cfg_wr_data[0];
        crpm_pkg::REG_MASK_OPACITY: cfg_r.mask_opacity <= cfg_wr_data[8:0];
        crpm_pkg::REG_RGB_LOWER:    cfg_r.rgb_lower <= cfg_wr_data;
        crpm_pkg::REG_RGB_UPPER:    cfg_r.rgb_upper <= cfg_wr_data;
        crpm_pkg::REG_HSV_LOWER:    cfg_r.hsv_lower <= cfg_wr_data;
        crpm_pkg::REG_HSV_UPPER:    cfg_r.hsv_upper <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  logic           fr_valid;
  logic           fr_ready;
  crpm_pkg::pix_t fr_pix;
  logic           dv_valid;
  logic           dv_ready;
  crpm_pkg::pix_t dv_pix;
  logic           cls_valid;
  logic           cls_ready;
  crpm_pkg::cls_t cls;

  crpm_hsv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_tvalid),
    .up_ready   (in_tready),
    .red        (in_tdata[7:0]),
    .green      (in_tdata[15:8]),
    .blue       (in_tdata[23:16]),
    .down_valid (fr_valid),
    .down_ready (fr_ready),
    .down_pix   (fr_pix)
  );

  crpm_div_pipe u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (fr_valid),
    .up_ready   (fr_ready),
    .up_pix     (fr_pix),
    .down_valid (dv_valid),
    .down_ready (dv_ready),
    .down_pix   (dv_pix)
  );

  crpm_classify u_cls (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .up_valid   (dv_valid),
    .up_ready   (dv_ready),
    .up_pix     (dv_pix),
    .down_valid (cls_valid),
    .down_ready (cls_ready),
    .down_cls   (cls)
  );

  // Output stage: dim non-matching pixels, saturating for opacity above 256.
  function automatic logic [7:0] scale_chan(logic [7:0] c, logic [8:0] opa);
    logic [16:0] prod;
    prod = {9'd0, c} * {8'd0, opa};
    return prod[16] ? 8'hFF : prod[15:8];
  endfunction

  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic [23:0] out_data_nxt;
  logic        out_hit_r;

  always_comb begin
    if (cls.hit) begin
      out_data_nxt = {cls.b, cls.g, cls.r};
    end else begin
      out_data_nxt = {scale_chan(cls.b, cfg_r.mask_opacity),
                      scale_chan(cls.g, cfg_r.mask_opacity),
                      scale_chan(cls.r, cfg_r.mask_opacity)};
    end
  end

  assign cls_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cls_ready) begin
      out_valid_r <= cls_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cls_ready && cls_valid) begin
      out_data_r <= out_data_nxt;
      out_hit_r <= cls.hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_hit_r;

  // An empty output register means every stage can take a transaction.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output register empty");

  // A result only appears when the classify stage held one.
  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cls_valid))
    else $error("result appeared from an empty pipeline");

  // Opacity, filter mode and HSV upper bound at their defaults in the first cycle after reset.
  a_cfg_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> (cfg_r.mask_opacity == crpm_pkg::RST_MASK_OPACITY) &&
                               (cfg_r.filter_mode == crpm_pkg::MODE_RGB) &&
                               (cfg_r.hsv_upper == crpm_pkg::RST_HSV_UPPER))
    else $error("configuration not at reset defaults");

endmodule
`default_nettype wire

/* hdl/crpm_hsv_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crpm_hsv_front
// First pipeline stage: finds max, min and sector of the pixel and forms the
// saturation and hue dividends.
// ----------------------------------------------------------------------------
module crpm_hsv_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire logic [7:0]      red,
  input  wire logic [7:0]      green,
  input  wire logic [7:0]      blue,
  output logic                 down_valid,
  input  wire logic            down_ready,
  output crpm_pkg::pix_t       down_pix
);

  logic           valid_r;
  crpm_pkg::pix_t pix_r;
  crpm_pkg::pix_t pix_nxt;

  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [7:0]  dlt;
  logic [7:0]  n;
  logic [15:0] s_num;
  logic [15:0] h_num;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    dlt = mx - mn;

    pix_nxt = '0;
    pix_nxt.r = red;
    pix_nxt.g = green;
    pix_nxt.b = blue;
    pix_nxt.v = mx;
    pix_nxt.d = dlt;
    priority if (mx == red) begin
      pix_nxt.sector = crpm_pkg::SEC_RED;
      pix_nxt.neg = green < blue;
      n = (green < blue) ? blue - green : green - blue;
    end else if (mx == green) begin
      pix_nxt.sector = crpm_pkg::SEC_GREEN;
      pix_nxt.neg = blue < red;
      n = (blue < red) ? red - blue : blue - red;
    end else begin
      pix_nxt.sector = crpm_pkg::SEC_BLUE;
      pix_nxt.neg = red < green;
      n = (red < green) ? green - red : red - green;
    end

    // Quotients stay below 256, so the upper byte starts as the remainder.
    s_num = {dlt, 8'd0} - {8'd0, dlt};
    h_num = {n, 6'd0} - {6'd0, n, 2'd0};
    pix_nxt.s_rem = s_num[15:8];
    pix_nxt.s_wrk = s_num[7:0];
    pix_nxt.h_rem = h_num[15:8];
    pix_nxt.h_wrk = h_num[7:0];
  end

  assign up_ready = !valid_r || down_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pix_r <= pix_nxt;
    end
  end

  assign down_valid = valid_r;
  assign down_pix = pix_r;

endmodule
`default_nettype wire

/* hdl/crpm_div_pipe.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crpm_div_pipe
// Pipelined restoring dividers for saturation and hue, two quotient bits per
// stage for both divisions side by side.
// ----------------------------------------------------------------------------
module crpm_div_pipe (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire crpm_pkg::pix_t  up_pix,
  output logic                 down_valid,
  input  wire logic            down_ready,
  output crpm_pkg::pix_t       down_pix
);

  logic           valid_r [crpm_pkg::DIV_STAGES];
  crpm_pkg::pix_t pix_r   [crpm_pkg::DIV_STAGES];
  logic           rdy     [crpm_pkg::DIV_STAGES];

  genvar s;
  generate
    for (s = 0; s < crpm_pkg::DIV_STAGES; s++) begin : g_stage
      logic           src_valid;
      crpm_pkg::pix_t src_pix;

      if (s == 0) begin : g_first
        assign src_valid = up_valid;
        assign src_pix = up_pix;
      end else begin : g_next
        assign src_valid = valid_r[s-1];
        assign src_pix = pix_r[s-1];
      end

      if (s == crpm_pkg::DIV_STAGES - 1) begin : g_last
        assign rdy[s] = !valid_r[s] || down_ready;
      end else begin : g_mid
        assign rdy[s] = !valid_r[s] || rdy[s+1];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[s] <= 1'b0;
        end else if (rdy[s]) begin
          valid_r[s] <= src_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[s] && src_valid) begin
          pix_r[s] <= crpm_pkg::div_advance(src_pix);
        end
      end
    end
  endgenerate

  assign up_ready = rdy[0];
  assign down_valid = valid_r[crpm_pkg::DIV_STAGES-1];
  assign down_pix = pix_r[crpm_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

/* hdl/crpm_classify.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crpm_classify
// Finishes the hue from the sector and quotient, then runs the RGB or HSV
// range test and registers the verdict with the original pixel.
// ----------------------------------------------------------------------------
module crpm_classify (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire crpm_pkg::cfg_t  cfg,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire crpm_pkg::pix_t  up_pix,
  output logic                 down_valid,
  input  wire logic            down_ready,
  output crpm_pkg::cls_t       down_cls
);

  logic           valid_r;
  crpm_pkg::cls_t cls_r;
  crpm_pkg::cls_t cls_nxt;

  logic [8:0] q9;
  logic [8:0] inexact9;
  logic [8:0] deg;
  logic [7:0] hue;
  logic [7:0] sat;
  logic [7:0] hlo;
  logic [7:0] hhi;
  logic       hue_ok;
  logic       sat_ok;
  logic       val_ok;
  logic       rgb_ok;

  always_comb begin
    q9 = {1'b0, up_pix.h_wrk};
    inexact9 = {8'd0, (up_pix.h_rem != 8'd0)};
    unique case (up_pix.sector)
      crpm_pkg::SEC_RED: begin
        // Red sector truncates toward zero, so a negative offset never rounds up.
        if (!up_pix.neg) deg = q9;
        else if (q9 == 9'd0) deg = 9'd0;
        else deg = 9'd360 - q9;
      end
      crpm_pkg::SEC_GREEN: begin
        deg = up_pix.neg ? 9'd120 - q9 - inexact9 : 9'd120 + q9;
      end
      default: begin
        deg = up_pix.neg ? 9'd240 - q9 - inexact9 : 9'd240 + q9;
      end
    endcase
    if (up_pix.d == 8'd0) deg = 9'd0;
    hue = deg[8:1];
    sat = (up_pix.v == 8'd0) ? 8'd0 : up_pix.s_wrk;

    hlo = cfg.hsv_lower[7:0];
    hhi = cfg.hsv_upper[7:0];
    if (hlo <= hhi) hue_ok = (hue >= hlo) && (hue <= hhi);
    else hue_ok = (hue >= hlo) || (hue <= hhi);
    sat_ok = (sat >= cfg.hsv_lower[15:8]) && (sat <= cfg.hsv_upper[15:8]);
    val_ok = (up_pix.v >= cfg.hsv_lower[23:16]) && (up_pix.v <= cfg.hsv_upper[23:16]);

    rgb_ok = (up_pix.r >= cfg.rgb_lower[7:0]) && (up_pix.r <= cfg.rgb_upper[7:0]) &&
             (up_pix.g >= cfg.rgb_lower[15:8]) && (up_pix.g <= cfg.rgb_upper[15:8]) &&
             (up_pix.b >= cfg.rgb_lower[23:16]) && (up_pix.b <= cfg.rgb_upper[23:16]);

    cls_nxt.r = up_pix.r;
    cls_nxt.g = up_pix.g;
    cls_nxt.b = up_pix.b;
    cls_nxt.hit = (cfg.filter_mode == crpm_pkg::MODE_HSV) ? (hue_ok && sat_ok && val_ok)
                                                          : rgb_ok;
  end

  assign up_ready = !valid_r || down_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      cls_r <= cls_nxt;
    end
  end

  assign down_valid = valid_r;
  assign down_cls = cls_r;

endmodule
`default_nettype wire
